// ----- hw/rtl/slcan_pkg.sv -----
package slcan_pkg;

  localparam int StepW = 5;
  localparam logic [StepW-1:0] LastStep = 5'd21;

  localparam int TsModulus = 60000;
  // 60000 = 32 * 1875: drop five bits, then divide by 1875 with a reciprocal
  localparam int TsPreShift = 5;
  localparam logic [27:0] TsRecip = 28'd146601551;  // ceil(2^38 / 1875)
  localparam int TsRecipShift = 38;

  // configuration register indexes
  localparam logic REG_LINK_OPEN = 1'b0;
  localparam logic REG_TS_ON = 1'b1;

  // character source select
  localparam logic [2:0] SRC_TYPE = 3'd0;
  localparam logic [2:0] SRC_ID = 3'd1;
  localparam logic [2:0] SRC_DLC = 3'd2;
  localparam logic [2:0] SRC_DATA = 3'd3;
  localparam logic [2:0] SRC_TS = 3'd4;
  localparam logic [2:0] SRC_CR = 3'd5;

  // jump conditions
  localparam logic [2:0] COND_NONE = 3'd0;
  localparam logic [2:0] COND_ALWAYS = 3'd1;
  localparam logic [2:0] COND_STD = 3'd2;
  localparam logic [2:0] COND_NO_DATA = 3'd3;
  localparam logic [2:0] COND_MORE_DATA = 3'd4;
  localparam logic [2:0] COND_TS_OFF = 3'd5;

  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef struct packed {
    logic             emit;
    logic [2:0]       src;
    logic [2:0]       nib;
    logic             wait_ts;
    logic             byte_step;
    logic             last;
    logic [2:0]       cond;
    logic [StepW-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic is_std;
    logic no_data;
    logic more_data;
    logic ts_off;
    logic ts_ready;
  } seq_flags_t;

  function automatic logic [7:0] hex_char(logic [3:0] n);
    hex_char = (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
  endfunction

  function automatic ctl_word_t ucode(logic [StepW-1:0] step);
    ctl_word_t w;
    w = '0;
    case (step)
      5'd0: begin
        w.emit = 1'b1; w.src = SRC_TYPE; w.cond = COND_STD; w.target = 5'd10;
      end
      5'd1: begin w.emit = 1'b1; w.src = SRC_ID; w.nib = 3'd7; end
      5'd2: begin w.emit = 1'b1; w.src = SRC_ID; w.nib = 3'd6; end
      5'd3: begin w.emit = 1'b1; w.src = SRC_ID; w.nib = 3'd5; end
      5'd4: begin w.emit = 1'b1; w.src = SRC_ID; w.nib = 3'd4; end
      5'd5: begin w.emit = 1'b1; w.src = SRC_ID; w.nib = 3'd3; end
      5'd6: begin w.emit = 1'b1; w.src = SRC_ID; w.nib = 3'd2; end
      5'd7: begin w.emit = 1'b1; w.src = SRC_ID; w.nib = 3'd1; end
      5'd8: begin
        w.emit = 1'b1; w.src = SRC_ID; w.nib = 3'd0;
        w.cond = COND_ALWAYS; w.target = 5'd13;
      end
      5'd10: begin w.emit = 1'b1; w.src = SRC_ID; w.nib = 3'd2; end
      5'd11: begin w.emit = 1'b1; w.src = SRC_ID; w.nib = 3'd1; end
      5'd12: begin w.emit = 1'b1; w.src = SRC_ID; w.nib = 3'd0; end
      5'd13: begin
        w.emit = 1'b1; w.src = SRC_DLC; w.cond = COND_NO_DATA; w.target = 5'd16;
      end
      5'd14: begin w.emit = 1'b1; w.src = SRC_DATA; w.nib = 3'd1; end
      5'd15: begin
        w.emit = 1'b1; w.src = SRC_DATA; w.nib = 3'd0; w.byte_step = 1'b1;
        w.cond = COND_MORE_DATA; w.target = 5'd14;
      end
      5'd16: begin w.cond = COND_TS_OFF; w.target = 5'd21; end
      5'd17: begin w.emit = 1'b1; w.src = SRC_TS; w.nib = 3'd3; w.wait_ts = 1'b1; end
      5'd18: begin w.emit = 1'b1; w.src = SRC_TS; w.nib = 3'd2; w.wait_ts = 1'b1; end
      5'd19: begin w.emit = 1'b1; w.src = SRC_TS; w.nib = 3'd1; w.wait_ts = 1'b1; end
      5'd20: begin w.emit = 1'b1; w.src = SRC_TS; w.nib = 3'd0; w.wait_ts = 1'b1; end
      5'd21: begin w.emit = 1'b1; w.src = SRC_CR; w.last = 1'b1; end
      default: begin w.last = 1'b1; end
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/slcan_ts_mod.sv -----
// now_ms mod 60000 by reciprocal multiply, three register stages:
// quotient product, quotient times 60000, then the subtract; done rises
// with the remainder
module slcan_ts_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] value,
  output logic        done,
  output logic [15:0] remainder
);

  logic [31:0] value_r;
  logic [54:0] prod;
  logic [16:0] quot;
  logic [31:0] back;
  logic        stage1;
  logic        stage2;

  assign quot = prod[slcan_pkg::TsRecipShift +: 17];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      stage2 <= stage1;
      if (start) done <= 1'b0;
      else if (stage2) done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      value_r <= value;
      prod    <= 55'(value[31:slcan_pkg::TsPreShift]) * 55'(slcan_pkg::TsRecip);
    end
    if (stage1) back <= 32'(33'(quot) * 33'(slcan_pkg::TsModulus));
    if (stage2) remainder <= 16'(value_r - back);
  end

endmodule

// ----- hw/rtl/slcan_seq.sv -----
// microcode step counter: one control word per step, conditional jumps
module slcan_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   advance,
  input  slcan_pkg::seq_flags_t  flags,
  output logic                   busy,
  output logic                   fire,
  output slcan_pkg::ctl_word_t   cw
);

  logic [slcan_pkg::StepW-1:0] step;
  logic taken;

  assign cw = slcan_pkg::ucode(step);

  always_comb begin
    case (cw.cond)
      slcan_pkg::COND_NONE:      taken = 1'b0;
      slcan_pkg::COND_ALWAYS:    taken = 1'b1;
      slcan_pkg::COND_STD:       taken = flags.is_std;
      slcan_pkg::COND_NO_DATA:   taken = flags.no_data;
      slcan_pkg::COND_MORE_DATA: taken = flags.more_data;
      slcan_pkg::COND_TS_OFF:    taken = flags.ts_off;
      default:                   taken = 1'b0;
    endcase
  end

  // timestamp steps hold until the remainder unit is done
  assign fire = busy && advance && !(cw.wait_ts && !flags.ts_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (fire) begin
      if (cw.last) begin
        busy <= 1'b0;
        step <= '0;
      end else if (taken) begin
        step <= cw.target;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

  a_fire_busy: assert property (@(posedge clk) disable iff (rst) fire |-> busy)
    else $error("step fired while idle");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> step <= slcan_pkg::LastStep)
    else $error("step counter beyond program");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    fire && cw.last |=> !busy)
    else $error("sequencer still busy after last step");
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("frame started while busy");

endmodule

// ----- hw/rtl/can_frame_to_slcan_text.sv -----
// CAN frame to SLCAN text line encoder.
// Input channel (in_valid / in_stall): one beat per received CAN frame. The
//   frame counter counts every accepted beat, also while the link is closed.
// Output channel (out_valid / out_stall): one beat per ASCII character, with
//   line_end set on the closing carriage return and frames_seen the counter
//   value including this frame.
// Config: cfg_write with cfg_index 0 = link_open, 1 = timestamps_on, bit 0 of
//   cfg_data. Write only while no line is in flight.
// Order: the frame beat starts the sequencer; its first step loads the first
//   character into the output register. The microcode program walks a line of
//   at most 31 characters, one per cycle unless held, plus one silent step.
// With timestamps on, the timestamp digits wait for the mod-60000 unit,
//   which the frame beat starts.
// in_stall is high while a line is being sent; one frame is handled at a
//   time, the next one taken in the cycle after the line's last step. When the
//   receiver stalls, the character holds in the output register and the
//   sequencer waits. A closed link drops the frame at once.
// Reset clears the counter and both config bits and empties the output.
module can_frame_to_slcan_text (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        extended,
  input  logic        remote,
  input  logic [28:0] identifier,
  input  logic [3:0]  length_code,
  input  logic [63:0] payload,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  text_char,
  output logic        line_end,
  output logic [31:0] frames_seen
);

  logic        link_open;
  logic        ts_on;
  logic [31:0] count;
  logic        ext_r;
  logic        rtr_r;
  logic [31:0] id_r;
  logic [3:0]  dlc_r;
  logic [63:0] data_r;
  logic [2:0]  byte_idx;
  logic [3:0]  nbytes;
  logic        accept;
  logic        start;
  logic        busy;
  logic        fire;
  logic        ts_done;
  logic [15:0] ts_val;
  logic [7:0]  byte_sel;
  logic [7:0]  char_sel;
  slcan_pkg::ctl_word_t  cw;
  slcan_pkg::seq_flags_t flags;

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign start    = accept && link_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_open <= 1'b0;
      ts_on     <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        slcan_pkg::REG_LINK_OPEN: link_open <= cfg_data;
        slcan_pkg::REG_TS_ON:     ts_on     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (accept) count <= count + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ext_r  <= extended;
      rtr_r  <= remote;
      id_r   <= {3'b000, identifier};
      dlc_r  <= length_code;
      data_r <= payload;
    end
  end

  always_ff @(posedge clk) begin
    if (start) byte_idx <= '0;
    else if (fire && cw.byte_step) byte_idx <= byte_idx + 1'b1;
  end

  assign nbytes = (dlc_r > 4'd8) ? 4'd8 : dlc_r;

  always_comb begin
    flags.is_std    = !ext_r;
    flags.no_data   = (nbytes == 4'd0);
    flags.more_data = (({1'b0, byte_idx} + 4'd1) != nbytes);
    flags.ts_off    = !ts_on;
    flags.ts_ready  = ts_done;
  end

  slcan_ts_mod u_ts_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .value     (now_ms),
    .done      (ts_done),
    .remainder (ts_val)
  );

  slcan_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .advance (!out_valid || !out_stall),
    .flags   (flags),
    .busy    (busy),
    .fire    (fire),
    .cw      (cw)
  );

  assign byte_sel = data_r[{byte_idx, 3'b000} +: 8];

  always_comb begin
    case (cw.src)
      slcan_pkg::SRC_TYPE:
        char_sel = ext_r ? (rtr_r ? "R" : "T") : (rtr_r ? "r" : "t");
      slcan_pkg::SRC_ID:   char_sel = slcan_pkg::hex_char(id_r[{cw.nib, 2'b00} +: 4]);
      slcan_pkg::SRC_DLC:  char_sel = slcan_pkg::hex_char(dlc_r);
      slcan_pkg::SRC_DATA: char_sel = slcan_pkg::hex_char(cw.nib[0] ? byte_sel[7:4]
                                                                    : byte_sel[3:0]);
      slcan_pkg::SRC_TS:   char_sel = slcan_pkg::hex_char(ts_val[{cw.nib[1:0], 2'b00} +: 4]);
      slcan_pkg::SRC_CR:   char_sel = slcan_pkg::CHAR_CR;
      default:             char_sel = slcan_pkg::CHAR_CR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (fire && cw.emit) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fire && cw.emit) begin
      text_char   <= char_sel;
      line_end    <= cw.last;
      frames_seen <= count;
    end
  end

  a_ts_ready: assert property (@(posedge clk) disable iff (rst)
    fire && cw.src == slcan_pkg::SRC_TS |-> ts_done)
    else $error("timestamp digit sent before remainder done");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !(fire && cw.emit))
    else $error("output register overwritten while stalled");

endmodule
